>>> hw/rtl/mf_pkg.sv
// Shared types and constants of the 5x5 median filter.
`timescale 1ns / 1ps
`default_nettype none
package mf_pkg;

   // Pixel and configuration field widths.
   localparam int PIX_W      = 8;
   localparam int WID_W      = 12;
   localparam int HGT_W      = 13;
   localparam int ROW_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int MAX_HEIGHT = 4096;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // Control handed to each row cell.
   typedef struct packed {
      logic rd_en;
      logic shift_en;
   } cell_ctl_type;

   // Control of one request moving into the median pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } item_ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/median_filter_5x5_unit.sv
// Top level of the streaming 5x5 median filter.
//
//  Channel  Direction  Payload                                 Handshake
//  req_     in         tdata[7:0] pixel                        tvalid / tready
//  rsp_     out        tdata[7:0] median_value, tlast          tvalid / tready
//  csr_     in         index (0 width, 1 height), data[12:0]   valid / ready
//
// One pixel is accepted per clock when the result side keeps up.
// A result passes the store read, the window shift and three median stages
// (compare, rank count, select) before it leaves.
// Reset clears the counters and the stage flags and sets the frame size to 640 by 480;
// line stores hold nothing meaningful until the first rows have passed.
// A stalled result holds only the stages behind it that are full; empty stages keep taking pixels.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_5x5_unit #(
   parameter int MAX_WIDTH   = 2048,
   parameter int WINDOW_SIDE = 5
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [mf_pkg::PIX_W-1:0]           req_tdata,   // [7:0] pixel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [mf_pkg::PIX_W-1:0]           rsp_tdata,   // [7:0] median_value
   output logic                               rsp_tlast,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [mf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [mf_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int MWB  = $clog2(MAX_WIDTH + 1);
   localparam int WCW  = (MWB > mf_pkg::WID_W) ? MWB : mf_pkg::WID_W;
   localparam int N    = WINDOW_SIDE * WINDOW_SIDE;

   logic [mf_pkg::WID_W-1:0]  width_ff;
   logic [mf_pkg::HGT_W-1:0]  height_ff;
   logic [WCW-1:0]            width_ext, w_eff, w_last, col_ext;
   logic [mf_pkg::HGT_W-1:0]  h_eff, h_last, row_ext;
   logic [AW-1:0]             col_ff, col_in;
   logic [mf_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                      req_accept, emit, last;
   logic                      a_valid_ff, a_emit_ff, a_last_ff;
   logic [mf_pkg::PIX_W-1:0]  a_pix_ff;
   logic [AW-1:0]             a_col_ff;
   logic                      w_valid_ff, w_last_ff, w_ready, a_adv, med_ready;
   mf_pkg::cell_ctl_type      cell_ctl;
   mf_pkg::item_ctl_type      med_ctl;
   logic [WINDOW_SIDE:0][mf_pkg::PIX_W-1:0]                 col_chain;
   logic [WINDOW_SIDE-1:0][WINDOW_SIDE-1:0][mf_pkg::PIX_W-1:0] rows;
   logic [N-1:0][mf_pkg::PIX_W-1:0]                          window;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf_pkg::WID_W'(640);
         height_ff <= mf_pkg::HGT_W'(480);
      end else if (csr_valid) begin
         unique case (csr_index)
            mf_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_data[mf_pkg::WID_W-1:0];
            end
            mf_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Frame size saturated into the supported range.
   always_comb begin
      width_ext = WCW'(width_ff);
      if (width_ext < WCW'(WINDOW_SIDE)) begin
         w_eff = WCW'(WINDOW_SIDE);
      end else if (width_ext > WCW'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = width_ext;
      end
      if (height_ff < mf_pkg::HGT_W'(WINDOW_SIDE)) begin
         h_eff = mf_pkg::HGT_W'(WINDOW_SIDE);
      end else if (height_ff > mf_pkg::HGT_W'(mf_pkg::MAX_HEIGHT)) begin
         h_eff = mf_pkg::HGT_W'(mf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      w_last  = w_eff - WCW'(1);
      h_last  = h_eff - mf_pkg::HGT_W'(1);
      col_ext = WCW'(col_ff);
      row_ext = mf_pkg::HGT_W'(row_ff);
   end

   // Raster position, result and end-of-frame flags of the request being accepted.
   assign req_accept = req_tvalid && req_tready;
   assign emit = (row_ff >= mf_pkg::ROW_W'(WINDOW_SIDE - 1)) && (col_ff >= AW'(WINDOW_SIDE - 1));
   assign last = (row_ext == h_last) && (col_ext == w_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_ext >= w_last) begin
         col_in = '0;
         row_in = (row_ext >= h_last) ? '0 : row_ff + mf_pkg::ROW_W'(1);
      end else begin
         col_in = col_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage A holds the pixel while its column is read from the line stores.
   assign w_ready    = !w_valid_ff || med_ready;
   assign a_adv      = a_valid_ff && w_ready;
   assign req_tready = !a_valid_ff || w_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            a_valid_ff <= req_tvalid;
         end
         if (w_ready) begin
            w_valid_ff <= a_valid_ff && a_emit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_pix_ff  <= req_tdata;
         a_col_ff  <= col_ff;
         a_emit_ff <= emit;
         a_last_ff <= last;
      end
      if (a_adv) begin
         w_last_ff <= a_last_ff;
      end
   end

   // Chain of row cells: each column value moves one row up through the stores.
   assign cell_ctl.rd_en    = req_accept;
   assign cell_ctl.shift_en = a_adv;
   assign col_chain[WINDOW_SIDE] = a_pix_ff;

   generate
      for (genvar k = 0; k < WINDOW_SIDE; k++) begin : g_row
         mf_row_cell #(
            .MAX_WIDTH   (MAX_WIDTH),
            .WINDOW_SIDE (WINDOW_SIDE),
            .HAS_STORE   (k < WINDOW_SIDE - 1)
         ) u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .rd_addr (col_ff),
            .wr_addr (a_col_ff),
            .col_in  (col_chain[k+1]),
            .col_out (col_chain[k]),
            .taps    (rows[k])
         );
         for (genvar j = 0; j < WINDOW_SIDE; j++) begin : g_tap
            assign window[k*WINDOW_SIDE + j] = rows[k][j];
         end
      end
   endgenerate

   // Median pipeline behind the window.
   assign med_ctl.valid = w_valid_ff;
   assign med_ctl.last  = w_last_ff;

   mf_median #(
      .WINDOW_SIDE (WINDOW_SIDE)
   ) u_median (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (med_ctl),
      .in_ready  (med_ready),
      .window    (window),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !a_valid_ff |-> req_tready) else $error("empty input stage refused a request");
   a_emit_moves: assert property (@(posedge clock) disable iff (reset)
      a_adv && a_emit_ff |=> w_valid_ff) else $error("window result lost");
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && (col_ext >= w_last) |=> col_ff == '0) else $error("column did not wrap");

endmodule
`default_nettype wire

>>> hw/rtl/mf_row_cell.sv
// One window row: an optional line store plus the row's window taps.
`timescale 1ns / 1ps
`default_nettype none
module mf_row_cell #(
   parameter int MAX_WIDTH   = 2048,
   parameter int WINDOW_SIDE = 5,
   parameter bit HAS_STORE   = 1'b1
) (
   input  wire                                          clock,
   input  wire  mf_pkg::cell_ctl_type                   ctl,
   input  wire  [$clog2(MAX_WIDTH)-1:0]                 rd_addr,
   input  wire  [$clog2(MAX_WIDTH)-1:0]                 wr_addr,
   input  wire  [mf_pkg::PIX_W-1:0]                     col_in,
   output logic [mf_pkg::PIX_W-1:0]                     col_out,
   output logic [WINDOW_SIDE-1:0][mf_pkg::PIX_W-1:0]    taps
);

   logic [WINDOW_SIDE-1:0][mf_pkg::PIX_W-1:0] taps_ff;

   generate
      if (HAS_STORE) begin : g_store
         logic [mf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
         logic [mf_pkg::PIX_W-1:0] rd_ff;

         // Read the older row on acceptance; write the newer one as the column moves on.
         always_ff @(posedge clock) begin
            if (ctl.rd_en) begin
               rd_ff <= mem[rd_addr];
            end
            if (ctl.shift_en) begin
               mem[wr_addr] <= col_in;
            end
         end
         assign col_out = rd_ff;
      end else begin : g_newest
         assign col_out = col_in;
      end
   endgenerate

   // The window row shifts left and takes this row's column value on the right.
   always_ff @(posedge clock) begin
      if (ctl.shift_en) begin
         for (int j = 0; j < WINDOW_SIDE - 1; j++) begin
            taps_ff[j] <= taps_ff[j+1];
         end
         taps_ff[WINDOW_SIDE-1] <= col_out;
      end
   end

   assign taps = taps_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mf_median.sv
// Three-stage rank-counting median of the window.
`timescale 1ns / 1ps
`default_nettype none
module mf_median #(
   parameter int WINDOW_SIDE = 5
) (
   input  wire                                                    clock,
   input  wire                                                    reset,
   input  wire  mf_pkg::item_ctl_type                             in_ctl,
   output logic                                                   in_ready,
   input  wire  [WINDOW_SIDE*WINDOW_SIDE-1:0][mf_pkg::PIX_W-1:0]  window,
   output logic                                                   out_valid,
   input  wire                                                    out_ready,
   output logic [mf_pkg::PIX_W-1:0]                               out_value,
   output logic                                                   out_last
);

   localparam int N  = WINDOW_SIDE * WINDOW_SIDE;
   localparam int RW = $clog2(N);
   localparam int LO = (N - 1) / 2;
   localparam int HI = N / 2;

   logic                                  v1_ff, v2_ff, v3_ff;
   logic                                  last1_ff, last2_ff, last3_ff;
   logic [N-1:0][mf_pkg::PIX_W-1:0]       val1_ff, val2_ff;
   logic [N-1:0][N-1:0]                   prec1_ff;
   logic [N-1:0][N-1:0]                   prec1_in;
   logic [N-1:0][RW-1:0]                  rank2_ff;
   logic [N-1:0][RW-1:0]                  rank2_in;
   logic [N-1:0]                          lo_hit, hi_hit;
   logic [mf_pkg::PIX_W-1:0]              lo_val, hi_val;
   logic [mf_pkg::PIX_W:0]                mid_sum;
   logic [mf_pkg::PIX_W-1:0]              value3_ff;
   logic                                  ready1, ready2, ready3;

   // Each stage moves on when it is empty or the next one is moving.
   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // Stage one: element j precedes element i, ties broken by position.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            prec1_in[i][j] = (window[j] < window[i]) || ((window[j] == window[i]) && (j < i));
         end
      end
   end

   // Stage two: the rank of each element is its count of predecessors.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         rank2_in[i] = RW'($countones(prec1_ff[i]));
      end
   end

   // Stage three: pick the middle element or elements by rank.
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < N; i++) begin
         lo_hit[i] = (rank2_ff[i] == RW'(LO));
         hi_hit[i] = (rank2_ff[i] == RW'(HI));
         lo_val    = lo_val | (lo_hit[i] ? val2_ff[i] : '0);
         hi_val    = hi_val | (hi_hit[i] ? val2_ff[i] : '0);
      end
      mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_ctl.valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (ready1 && in_ctl.valid) begin
         val1_ff  <= window;
         prec1_ff <= prec1_in;
         last1_ff <= in_ctl.last;
      end
      if (ready2 && v1_ff) begin
         val2_ff  <= val1_ff;
         rank2_ff <= rank2_in;
         last2_ff <= last1_ff;
      end
      if (ready3 && v2_ff) begin
         value3_ff <= mid_sum[mf_pkg::PIX_W:1];
         last3_ff  <= last2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = value3_ff;
   assign out_last  = last3_ff;

   // Ranks form a permutation, so each middle rank belongs to exactly one element.
   a_lo_unique: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $onehot(lo_hit)) else $error("lower middle rank not unique");
   a_hi_unique: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $onehot(hi_hit)) else $error("upper middle rank not unique");
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ready3 |=> v2_ff) else $error("stalled median stage lost its request");

endmodule
`default_nettype wire
